// ===== design/rfva_pkg.sv =====
package rfva_pkg;

   localparam int MAX_CAND = 64;
   localparam int MAX_DIM  = 64;
   localparam int CAND_W   = $clog2(MAX_CAND);
   localparam int CNT_W    = CAND_W + 1;
   localparam int DIM_W    = 6;
   localparam int LEN_W    = 7;
   localparam int VEC_AW   = CAND_W + DIM_W;
   localparam int VEC_D    = MAX_CAND * MAX_DIM;
   localparam int W_W      = 33;
   localparam int DEN_W    = W_W + CAND_W;
   localparam int NUM_W    = 56;
   localparam int DIV_NW   = 58;
   localparam int DIV_DW   = DEN_W + 2;
   localparam int DIV_CW   = $clog2(DIV_NW + 1);
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 24;

   localparam logic [1:0] REG_FUSION_MODE   = 2'd0;
   localparam logic [1:0] REG_KEEP_COUNT    = 2'd1;
   localparam logic [1:0] REG_VECTOR_LENGTH = 2'd2;

   localparam logic [1:0] MODE_EQUAL = 2'd0;
   localparam logic [1:0] MODE_PROD  = 2'd1;
   localparam logic [1:0] MODE_DIST  = 2'd2;
   localparam logic [1:0] MODE_CONN  = 2'd3;

   typedef struct packed {
      logic                start;
      logic [DIV_NW-1:0]   dividend;
      logic [DIV_DW-1:0]   divisor;
   } div_req_type;

endpackage

// ===== design/rfva_ram.sv =====
module rfva_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== design/rfva_div.sv =====
module rfva_div (
   input  logic                       clock,
   input  logic                       reset,
   input  rfva_pkg::div_req_type      req,
   output logic [rfva_pkg::DIV_NW-1:0] quotient,
   output logic                       done
);
   import rfva_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] dvs_ff, dvs_in;
   logic [DIV_DW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIV_NW-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIV_DW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

// ===== design/rank_fused_vector_average.sv =====
// Reciprocal-rank weighted vector average.
// Candidates stream in on the req_ channel, one vector coordinate per transaction;
// a transaction with coordinate index zero opens a new candidate. Every transaction
// offered while loading is taken. The transaction with req_tlast set and the final
// coordinate index starts the computation, and req_tready stays low until the run
// is delivered. The computation runs on one comparator sweep, one 16x16 multiplier,
// one 34x16 multiplier and one shared bit-serial divider: ranking and ordering
// sweep the candidates, and the divider runs once per kept candidate for weighting
// and once per result coordinate. Results leave on the rsp_ channel one coordinate
// per transaction, the last with rsp_tlast; an empty run gives one transaction with
// rsp_tuser set. A stalled receiver holds the result register and the sequencer.
// Registers are written over the csr_ port, by the user only while the block is
// idle; the block does not enforce this. Reset empties the candidate set and loads
// the register defaults; the stores need no clearing.
module rank_fused_vector_average (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // cand_id, distance_key, degree, given_dist_rank, given_conn_rank,
   // coord_index, coord_value
   input  logic [rfva_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_index, out_value
   output logic [rfva_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   // out_empty
   output logic                                 rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [3:0]                           csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import rfva_pkg::*;

   typedef enum logic [4:0] {
      S_LOAD, S_RK_I, S_RK_LAT, S_RK_J, S_RK_CMP, S_RK_SC,
      S_PS_I, S_PS_LAT, S_PS_J, S_PS_CMP, S_PS_WR,
      S_WT_K, S_WT_C, S_WT_S, S_WT_DIV,
      S_AC_J, S_AC_K, S_AC_V, S_AC_M, S_AC_ADD, S_AC_DIVS, S_AC_DIVW, S_OUT
   } state_type;

   state_type          state_ff;
   logic [1:0]         mode_ff;
   logic [LEN_W-1:0]   keep_ff, vlen_ff;
   logic [CNT_W-1:0]   loaded_ff, loaded_in;
   logic [1:0]         given_ff, given_in;
   logic               accepting_ff, accepting_in;
   logic [CNT_W-1:0]   i_ff, j_ff, k_ff, pos_ff;
   logic [15:0]        dr_ff, cr_ff, gdri_ff, gcri_ff, degi_ff;
   logic [31:0]        di_ff, si_ff, idi_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [49:0]        prod_ff;
   logic               rsp_valid_ff, rsp_last_ff, rsp_empty_ff;
   logic [DIM_W-1:0]   rsp_index_ff;
   logic [15:0]        rsp_value_ff;

   logic               req_acc, opening, cand_we, vec_we, trigger;
   logic [DIM_W-1:0]   coord;
   logic [LEN_W-1:0]   len, sel;
   logic [CAND_W-1:0]  cand_ra, order_rd;
   logic [31:0]        id_rd, dist_rd, score_rd, sc;
   logic [15:0]        deg_rd, gdr_rd, gcr_rd, vec_rd, drsel, crsel;
   logic [W_W-1:0]     w_rd, w_new;
   logic [VEC_AW-1:0]  vec_wa;
   logic [NUM_W-1:0]   mag;
   logic [DIV_NW-1:0]  quo;
   logic               div_done;
   div_req_type        div_req;
   logic [15:0]        val;

   assign coord   = req_tdata[117:112];
   assign req_tready = (state_ff == S_LOAD);
   assign req_acc = req_tvalid && req_tready;
   assign opening = (coord == '0);
   assign len = (vlen_ff == '0) ? LEN_W'(1) :
                (vlen_ff > LEN_W'(MAX_DIM)) ? LEN_W'(MAX_DIM) : vlen_ff;
   assign sel = (keep_ff < LEN_W'(loaded_ff)) ? keep_ff : LEN_W'(loaded_ff);

   always_comb begin
      loaded_in    = loaded_ff;
      given_in     = given_ff;
      accepting_in = accepting_ff;
      cand_we      = 1'b0;
      if (req_acc && opening) begin
         if (loaded_ff < CNT_W'(MAX_CAND)) begin
            cand_we      = 1'b1;
            loaded_in    = loaded_ff + 1'b1;
            accepting_in = 1'b1;
            if (req_tdata[95:80] == '0) given_in[0] = 1'b0;
            if (req_tdata[111:96] == '0) given_in[1] = 1'b0;
         end else begin
            accepting_in = 1'b0;
         end
      end
   end

   assign vec_we  = req_acc && accepting_in && (loaded_in != '0) && (LEN_W'(coord) < len);
   assign vec_wa  = {CAND_W'(loaded_in - 1'b1), coord};
   assign trigger = req_acc && req_tlast && (LEN_W'(coord) + 1'b1 == len);

   always_comb begin
      unique case (state_ff)
         S_RK_I, S_PS_I: cand_ra = i_ff[CAND_W-1:0];
         S_RK_J, S_PS_J: cand_ra = j_ff[CAND_W-1:0];
         default:        cand_ra = order_rd;
      endcase
   end

   assign drsel = given_ff[0] ? gdri_ff : dr_ff;
   assign crsel = given_ff[1] ? gcri_ff : cr_ff;
   always_comb begin
      unique case (mode_ff)
         MODE_PROD: sc = drsel * crsel;
         MODE_DIST: sc = {16'd0, drsel};
         MODE_CONN: sc = {16'd0, crsel};
         default:   sc = 32'd1;
      endcase
   end

   assign w_new = W_W'((quo + 1'b1) >> 1);
   assign mag   = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : num_ff;

   always_comb begin
      div_req = '0;
      if (state_ff == S_WT_S) begin
         div_req.start    = 1'b1;
         div_req.dividend = DIV_NW'(1) << 33;
         div_req.divisor  = DIV_DW'(score_rd);
      end else if (state_ff == S_AC_DIVS) begin
         div_req.start    = 1'b1;
         div_req.dividend = (DIV_NW'(mag) << 1) + DIV_NW'(den_ff);
         div_req.divisor  = DIV_DW'(den_ff) << 1;
      end
   end

   always_comb begin
      if (num_ff[NUM_W-1]) begin
         val = (quo > DIV_NW'(32768)) ? 16'h8000 : 16'(17'd0 - 17'(quo));
      end else begin
         val = (quo > DIV_NW'(32767)) ? 16'h7FFF : 16'(quo);
      end
   end

   rfva_ram #(.WIDTH(32), .DEPTH(MAX_CAND)) u_id (
      .clock(clock), .we(cand_we), .waddr(loaded_ff[CAND_W-1:0]),
      .wdata(req_tdata[31:0]), .raddr(cand_ra), .rdata(id_rd));
   rfva_ram #(.WIDTH(32), .DEPTH(MAX_CAND)) u_dist (
      .clock(clock), .we(cand_we), .waddr(loaded_ff[CAND_W-1:0]),
      .wdata(req_tdata[63:32]), .raddr(cand_ra), .rdata(dist_rd));
   rfva_ram #(.WIDTH(16), .DEPTH(MAX_CAND)) u_deg (
      .clock(clock), .we(cand_we), .waddr(loaded_ff[CAND_W-1:0]),
      .wdata(req_tdata[79:64]), .raddr(cand_ra), .rdata(deg_rd));
   rfva_ram #(.WIDTH(16), .DEPTH(MAX_CAND)) u_gdr (
      .clock(clock), .we(cand_we), .waddr(loaded_ff[CAND_W-1:0]),
      .wdata(req_tdata[95:80]), .raddr(cand_ra), .rdata(gdr_rd));
   rfva_ram #(.WIDTH(16), .DEPTH(MAX_CAND)) u_gcr (
      .clock(clock), .we(cand_we), .waddr(loaded_ff[CAND_W-1:0]),
      .wdata(req_tdata[111:96]), .raddr(cand_ra), .rdata(gcr_rd));
   rfva_ram #(.WIDTH(16), .DEPTH(VEC_D)) u_vec (
      .clock(clock), .we(vec_we), .waddr(vec_wa), .wdata(req_tdata[133:118]),
      .raddr({order_rd, j_ff[DIM_W-1:0]}), .rdata(vec_rd));
   rfva_ram #(.WIDTH(32), .DEPTH(MAX_CAND)) u_score (
      .clock(clock), .we(state_ff == S_RK_SC), .waddr(i_ff[CAND_W-1:0]),
      .wdata(sc), .raddr(cand_ra), .rdata(score_rd));
   rfva_ram #(.WIDTH(CAND_W), .DEPTH(MAX_CAND)) u_order (
      .clock(clock), .we(state_ff == S_PS_WR), .waddr(pos_ff[CAND_W-1:0]),
      .wdata(i_ff[CAND_W-1:0]), .raddr(k_ff[CAND_W-1:0]), .rdata(order_rd));
   rfva_ram #(.WIDTH(W_W), .DEPTH(MAX_CAND)) u_w (
      .clock(clock), .we((state_ff == S_WT_DIV) && div_done),
      .waddr(k_ff[CAND_W-1:0]), .wdata(w_new), .raddr(k_ff[CAND_W-1:0]), .rdata(w_rd));

   rfva_div u_div (
      .clock(clock), .reset(reset), .req(div_req), .quotient(quo), .done(div_done));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         mode_ff      <= MODE_PROD;
         keep_ff      <= LEN_W'(8);
         vlen_ff      <= LEN_W'(64);
         loaded_ff    <= '0;
         given_ff     <= 2'b11;
         accepting_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            unique case (csr_paddr[3:2])
               REG_FUSION_MODE:   mode_ff <= csr_pwdata[1:0];
               REG_KEEP_COUNT:    keep_ff <= csr_pwdata[LEN_W-1:0];
               REG_VECTOR_LENGTH: vlen_ff <= csr_pwdata[LEN_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_LOAD: begin
               loaded_ff    <= loaded_in;
               given_ff     <= given_in;
               accepting_ff <= accepting_in;
               if (trigger) begin
                  i_ff <= '0;
                  if (loaded_in == '0 || keep_ff == '0) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_last_ff  <= 1'b1;
                     rsp_empty_ff <= 1'b1;
                     rsp_index_ff <= '0;
                     rsp_value_ff <= '0;
                     state_ff     <= S_OUT;
                  end else begin
                     state_ff <= S_RK_I;
                  end
               end
            end
            S_RK_I: state_ff <= S_RK_LAT;
            S_RK_LAT: begin
               di_ff    <= dist_rd;
               degi_ff  <= deg_rd;
               gdri_ff  <= gdr_rd;
               gcri_ff  <= gcr_rd;
               dr_ff    <= 16'd1;
               cr_ff    <= 16'd1;
               j_ff     <= '0;
               state_ff <= S_RK_J;
            end
            S_RK_J: state_ff <= S_RK_CMP;
            S_RK_CMP: begin
               if ($signed(dist_rd) < $signed(di_ff)) dr_ff <= dr_ff + 1'b1;
               if (deg_rd > degi_ff) cr_ff <= cr_ff + 1'b1;
               j_ff     <= j_ff + 1'b1;
               state_ff <= (j_ff + 1'b1 == loaded_ff) ? S_RK_SC : S_RK_J;
            end
            S_RK_SC: begin
               i_ff     <= (i_ff + 1'b1 == loaded_ff) ? '0 : i_ff + 1'b1;
               state_ff <= (i_ff + 1'b1 == loaded_ff) ? S_PS_I : S_RK_I;
            end
            S_PS_I: state_ff <= S_PS_LAT;
            S_PS_LAT: begin
               si_ff  <= score_rd;
               idi_ff <= id_rd;
               j_ff   <= '0;
               if (mode_ff == MODE_EQUAL) begin
                  pos_ff   <= i_ff;
                  state_ff <= S_PS_WR;
               end else begin
                  pos_ff   <= '0;
                  state_ff <= S_PS_J;
               end
            end
            S_PS_J: state_ff <= S_PS_CMP;
            S_PS_CMP: begin
               if (score_rd < si_ff || (score_rd == si_ff && id_rd < idi_ff) ||
                   (score_rd == si_ff && id_rd == idi_ff && j_ff < i_ff)) begin
                  pos_ff <= pos_ff + 1'b1;
               end
               j_ff     <= j_ff + 1'b1;
               state_ff <= (j_ff + 1'b1 == loaded_ff) ? S_PS_WR : S_PS_J;
            end
            S_PS_WR: begin
               i_ff <= i_ff + 1'b1;
               if (i_ff + 1'b1 == loaded_ff) begin
                  k_ff     <= '0;
                  den_ff   <= '0;
                  state_ff <= S_WT_K;
               end else begin
                  state_ff <= S_PS_I;
               end
            end
            S_WT_K: state_ff <= S_WT_C;
            S_WT_C: state_ff <= S_WT_S;
            S_WT_S: state_ff <= S_WT_DIV;
            S_WT_DIV: begin
               if (div_done) begin
                  den_ff <= den_ff + DEN_W'(w_new);
                  k_ff   <= k_ff + 1'b1;
                  if (LEN_W'(k_ff) + 1'b1 == sel) begin
                     j_ff     <= '0;
                     state_ff <= S_AC_J;
                  end else begin
                     state_ff <= S_WT_K;
                  end
               end
            end
            S_AC_J: begin
               num_ff   <= '0;
               k_ff     <= '0;
               state_ff <= S_AC_K;
            end
            S_AC_K: state_ff <= S_AC_V;
            S_AC_V: state_ff <= S_AC_M;
            S_AC_M: begin
               prod_ff  <= $signed({1'b0, w_rd}) * $signed(vec_rd);
               state_ff <= S_AC_ADD;
            end
            S_AC_ADD: begin
               num_ff   <= num_ff + NUM_W'($signed(prod_ff));
               k_ff     <= k_ff + 1'b1;
               state_ff <= (LEN_W'(k_ff) + 1'b1 == sel) ? S_AC_DIVS : S_AC_K;
            end
            S_AC_DIVS: state_ff <= S_AC_DIVW;
            S_AC_DIVW: begin
               if (div_done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= (LEN_W'(j_ff) + 1'b1 == len);
                  rsp_empty_ff <= 1'b0;
                  rsp_index_ff <= j_ff[DIM_W-1:0];
                  rsp_value_ff <= val;
                  state_ff     <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     loaded_ff    <= '0;
                     given_ff     <= 2'b11;
                     accepting_ff <= 1'b0;
                     state_ff     <= S_LOAD;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= S_AC_J;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_FUSION_MODE:   csr_prdata = {30'd0, mode_ff};
         REG_KEEP_COUNT:    csr_prdata = {25'd0, keep_ff};
         REG_VECTOR_LENGTH: csr_prdata = {25'd0, vlen_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_value_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import rfva_pkg::*;

   localparam int IDLE_LIMIT = 100000;

   typedef struct {
      logic [31:0]        id;
      logic signed [31:0] dist_key;
      logic [15:0]        degree;
      logic [15:0]        dist_rank;
      logic [15:0]        conn_rank;
      logic [5:0]         coord;
      logic signed [15:0] value;
      logic               last;
   } coord_item_type;

   typedef struct packed {
      logic [5:0]  index;
      logic [15:0] value;
      logic        last;
      logic        empty;
   } mean_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   rank_fused_vector_average DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   coord_item_type pending_coords[$];
   mean_item_type  expected_means[$];
   coord_item_type driven_coord;
   int accepted_coords = 0;
   int consumed_coords = 0;
   int burst_left = 0;
   int gap_left = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int items_made = 0;

   // Shadow of the block's registers and candidate stores.
   logic [1:0]  mode_reg = MODE_PROD;
   logic [6:0]  keep_reg = 7'd8;
   logic [6:0]  length_reg = 7'd64;
   logic [31:0]        id_mem[MAX_CAND];
   logic signed [31:0] dist_mem[MAX_CAND];
   logic [15:0]        degree_mem[MAX_CAND];
   logic [15:0]        drank_mem[MAX_CAND];
   logic [15:0]        crank_mem[MAX_CAND];
   logic signed [15:0] coord_mem[MAX_CAND][MAX_DIM];
   int   cand_count = 0;
   logic [1:0] ranks_supplied = 2'b11;
   logic slot_open = 1'b0;

   function automatic int active_length();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_DIM) return MAX_DIM;
      return length_reg;
   endfunction

   task automatic fuse_candidates();
      longint unsigned score[MAX_CAND];
      longint unsigned weight[MAX_CAND];
      int rank_order[MAX_CAND];
      longint unsigned dr, cr, den, mag, q;
      longint num, val;
      int pos, kept, c, len;
      mean_item_type m;
      len = active_length();
      den = 0;
      if (cand_count == 0 || keep_reg == 0) begin
         m = '{index: 6'd0, value: 16'd0, last: 1'b1, empty: 1'b1};
         expected_means.push_back(m);
         return;
      end
      for (int i = 0; i < cand_count; i++) begin
         dr = 1;
         cr = 1;
         if (ranks_supplied[0]) dr = drank_mem[i];
         else for (int j = 0; j < cand_count; j++) if (dist_mem[j] < dist_mem[i]) dr++;
         if (ranks_supplied[1]) cr = crank_mem[i];
         else for (int j = 0; j < cand_count; j++) if (degree_mem[j] > degree_mem[i]) cr++;
         case (mode_reg)
            MODE_PROD: score[i] = dr * cr;
            MODE_DIST: score[i] = dr;
            MODE_CONN: score[i] = cr;
            default: score[i] = 1;
         endcase
      end
      for (int i = 0; i < cand_count; i++) begin
         pos = 0;
         if (mode_reg == MODE_EQUAL) pos = i;
         else for (int j = 0; j < cand_count; j++)
            if (score[j] < score[i] || (score[j] == score[i] && id_mem[j] < id_mem[i]) ||
                (score[j] == score[i] && id_mem[j] == id_mem[i] && j < i)) pos++;
         rank_order[pos] = i;
      end
      kept = keep_reg < cand_count ? keep_reg : cand_count;
      for (int k = 0; k < kept; k++) begin
         weight[k] = ((64'd1 << 33) / score[rank_order[k]] + 1) >> 1;
         den += weight[k];
      end
      for (int j = 0; j < len; j++) begin
         num = 0;
         for (int k = 0; k < kept; k++) begin
            c = rank_order[k];
            num += longint'(weight[k]) * longint'(coord_mem[c][j]);
         end
         mag = num < 0 ? longint'(-num) : num;
         q = (mag * 2 + den) / (den * 2);
         if (q > 32768) q = 32768;
         val = num < 0 ? -longint'(q) : longint'(q);
         if (val > 32767) val = 32767;
         m = '{index: j[5:0], value: val[15:0], last: (j + 1 == len), empty: 1'b0};
         expected_means.push_back(m);
      end
   endtask

   task automatic absorb_coord(coord_item_type t);
      int s;
      if (t.coord == 0) begin
         if (cand_count < MAX_CAND) begin
            s = cand_count;
            cand_count++;
            id_mem[s] = t.id;
            dist_mem[s] = t.dist_key;
            degree_mem[s] = t.degree;
            drank_mem[s] = t.dist_rank;
            crank_mem[s] = t.conn_rank;
            if (t.dist_rank == 0) ranks_supplied[0] = 1'b0;
            if (t.conn_rank == 0) ranks_supplied[1] = 1'b0;
            slot_open = 1'b1;
         end else begin
            slot_open = 1'b0;
         end
      end
      if (slot_open && cand_count > 0 && t.coord < active_length())
         coord_mem[cand_count-1][t.coord] = t.value;
      if (t.last && t.coord + 1 == active_length()) begin
         fuse_candidates();
         cand_count = 0;
         ranks_supplied = 2'b11;
         slot_open = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      mean_item_type got, want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready) begin
            absorb_coord(driven_coord);
            accepted_coords++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{index: rsp_tdata[5:0], value: rsp_tdata[21:6], last: rsp_tlast,
                    empty: rsp_tuser};
            if (expected_means.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected result transaction: index %0d value %0d", got.index,
                           $signed(got.value));
            end else begin
               want = expected_means.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                              want.index, $signed(want.value), want.last, want.empty,
                              got.index, $signed(got.value), got.last, got.empty);
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      logic next_valid;
      coord_item_type t;
      next_valid = req_tvalid;
      if (req_tvalid && accepted_coords != consumed_coords) begin
         consumed_coords = accepted_coords;
         next_valid = 1'b0;
      end
      if (!next_valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_coords.size() > 0) begin
            t = pending_coords.pop_front();
            driven_coord <= t;
            req_tdata <= {2'b00, t.value, t.coord, t.conn_rank, t.dist_rank, t.degree,
                          t.dist_key, t.id};
            req_tlast <= t.last;
            next_valid = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_tvalid <= next_valid;
   end

   int sink_cycle = 0;
   int hold_left = 0;
   bit held_once = 1'b0;
   int stall_style = 0;

   always @(negedge clock) begin
      sink_cycle++;
      if (sink_cycle % 256 == 0) stall_style = $urandom_range(0, 2);
      if (!held_once && rsp_tvalid && pending_coords.size() > 0) begin
         held_once = 1'b1;
         hold_left = 1500;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_FUSION_MODE: mode_reg = value[1:0];
         REG_KEEP_COUNT: keep_reg = value[6:0];
         default: length_reg = value[6:0];
      endcase
   endtask

   task automatic drain();
      wait (pending_coords.size() == 0 && !req_tvalid && expected_means.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic setup(logic [1:0] mode, logic [6:0] keep, logic [6:0] len);
      drain();
      csr_write(REG_FUSION_MODE, mode);
      csr_write(REG_KEEP_COUNT, keep);
      csr_write(REG_VECTOR_LENGTH, len);
   endtask

   function automatic logic [15:0] pick16(bit tight);
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return tight ? 16'($urandom_range(0, 4)) : 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick32(bit tight);
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return tight ? 32'($urandom_range(0, 4)) : $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_rank(bit supplied);
      logic [15:0] r;
      if (!supplied && $urandom_range(0, 1)) return 16'd0;
      r = ($urandom_range(0, 1)) ? 16'($urandom_range(1, 8)) : pick16(1'b0);
      return (r == 0) ? 16'd1 : r;
   endfunction

   // Queues one run: candidates with full vectors, optional stray coordinates, and the
   // final coordinate of the last candidate that starts the computation.
   task automatic queue_run(int cands, bit supplied, bit noisy);
      coord_item_type t;
      int len;
      bit tight;
      len = active_length();
      tight = $urandom_range(0, 1);
      if (noisy && len > 1) begin
         t = '{id: $urandom, dist_key: $urandom, degree: 16'($urandom),
               dist_rank: 16'($urandom), conn_rank: 16'($urandom),
               coord: 6'($urandom_range(1, 63)), value: 16'($urandom), last: 1'b0};
         pending_coords.push_back(t);
         items_made++;
      end
      for (int c = 0; c < cands; c++) begin
         t.id = pick32(tight);
         t.dist_key = pick32(tight);
         t.degree = pick16(tight);
         t.dist_rank = pick_rank(supplied);
         t.conn_rank = pick_rank(supplied);
         t.last = (c == cands - 1);
         for (int j = 0; j < len; j++) begin
            t.coord = 6'(j);
            t.value = pick16(1'b0);
            pending_coords.push_back(t);
            items_made++;
            if (noisy && len < MAX_DIM && j < len - 1 && $urandom_range(0, 3) == 0) begin
               t.coord = 6'($urandom_range(len, 63));
               t.value = 16'($urandom);
               pending_coords.push_back(t);
               items_made++;
            end
         end
      end
   endtask

   initial begin
      logic [6:0] len;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty runs: a trigger with nothing loaded, then a keep count of zero.
      setup(MODE_PROD, 7'd0, 7'd2);
      queue_run(0, 1'b1, 1'b0);
      pending_coords.push_back('{id: 0, dist_key: 0, degree: 0, dist_rank: 0, conn_rank: 0,
                                 coord: 6'd1, value: 16'sd5, last: 1'b1});
      queue_run(1, 1'b0, 1'b0);
      for (int m = 0; m < 4; m++) begin
         setup(m[1:0], 7'd3, 7'd2);
         queue_run(3, m[0], m[1]);
      end
      setup(MODE_DIST, 7'd64, 7'd0);
      queue_run(66, 1'b0, 1'b0);
      setup(MODE_CONN, 7'd127, 7'd127);
      queue_run(1, 1'b1, 1'b0);
      setup(MODE_PROD, 7'd2, 7'd64);
      queue_run(2, 1'b0, 1'b0);

      while (items_made < 350) begin
         len = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
                                             7'($urandom_range(1, 8));
         setup(2'($urandom_range(0, 3)),
               ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127)) :
                                             7'($urandom_range(1, 6)), len);
         repeat ($urandom_range(1, 3))
            queue_run((active_length() > 16) ? $urandom_range(1, 2) : $urandom_range(1, 7),
                      $urandom_range(0, 1), $urandom_range(0, 3) == 0);
      end

      drain();
      if (mismatch_count == 0 && expected_means.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
